/* rtl/rcm_pkg.sv */
`default_nettype none

package rcm_pkg;

	localparam int MAX_DIM      = 4096;
	localparam int DIM_W        = 13;
	localparam int CNT_W        = 12;
	localparam int RAD_W        = 13;
	localparam int COLOR_W      = 32;
	localparam int CFG_W        = 45;
	localparam int CFG_IDX_W    = 3;
	localparam int CHAN_W       = 8;
	localparam int NCORNER      = 4;
	localparam int DIFF_W       = 15;
	localparam int MAG_W        = 14;
	localparam int SQ_W         = 2 * MAG_W;
	localparam int RSQ_W        = 2 * RAD_W;
	localparam int SUM_W        = SQ_W + 1;
	localparam int QDEPTH       = 2;
	localparam int PTR_W        = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);
	localparam int MAX_INFLIGHT = QDEPTH + 2;
	localparam int INFL_W       = $clog2(MAX_INFLIGHT + 1);

	localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

	localparam int C_TL = 0;
	localparam int C_TR = 1;
	localparam int C_BL = 2;
	localparam int C_BR = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH,
		CFG_IMAGE_HEIGHT,
		CFG_PIXEL_FORMAT,
		CFG_CORNER_TL,
		CFG_CORNER_TR,
		CFG_CORNER_BL,
		CFG_CORNER_BR
	} cfg_idx_t;

	typedef struct packed {
		logic [RAD_W-1:0]   radius;
		logic [COLOR_W-1:0] color;
	} corner_t;

	typedef struct packed {
		logic [DIM_W-1:0]          width;
		logic [DIM_W-1:0]          height;
		logic                      rgba;
		corner_t [NCORNER-1:0]     corner;
	} cfg_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} pixel_t;

	typedef struct packed {
		pixel_t                        pix;
		logic                          frame_end;
		logic [NCORNER-1:0]            in_sq;
		logic [NCORNER-1:0][MAG_W-1:0] mag_x;
		logic [NCORNER-1:0][MAG_W-1:0] mag_y;
	} work_t;

	typedef struct packed {
		logic push;
	} q_wr_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] res;
		res = v;
		if (v == '0)
			res = DIM_W'(1);
		else if (v > MAX_DIM_V)
			res = MAX_DIM_V;
		return res;
	endfunction

	function automatic logic [MAG_W-1:0] mag_of(input logic [DIFF_W-1:0] d);
		logic [DIFF_W-1:0] neg;
		neg = ~d + DIFF_W'(1);
		return d[DIFF_W-1] ? neg[MAG_W-1:0] : d[MAG_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/rcm_ifs.sv */
`default_nettype none

interface rcm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic [7:0] in_alpha;

	modport source (output valid, output in_red, output in_green, output in_blue,
		output in_alpha, input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue,
		input in_alpha, output ready);
endinterface

interface rcm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic       was_filled;
	logic       frame_end;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output out_alpha, output was_filled, output frame_end, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input out_alpha, input was_filled, input frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/rcm_front.sv */
`default_nettype none

module rcm_front import rcm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rcm_in_if.sink     pix_in,
	input  cfg_t       cfg,
	output q_wr_t      wr,
	input  wire logic  q_full,
	output work_t      push_data
);

	logic [CNT_W-1:0]  col_q;
	logic [CNT_W-1:0]  row_q;
	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic [DIM_W-1:0]  col_inc;
	logic [DIM_W-1:0]  row_inc;
	logic              last_col;
	logic              last_row;
	logic              in_frame;
	logic [DIFF_W-1:0] xs;
	logic [DIFF_W-1:0] ys;
	logic [DIFF_W-1:0] ws;
	logic [DIFF_W-1:0] hs;
	logic [DIFF_W-1:0] rs [NCORNER];
	logic [DIFF_W-1:0] dx [NCORNER];
	logic [DIFF_W-1:0] dy [NCORNER];
	logic              hit_x [NCORNER];
	logic              hit_y [NCORNER];

	assign w_eff    = eff_dim(cfg.width);
	assign h_eff    = eff_dim(cfg.height);
	assign col_inc  = DIM_W'(col_q) + DIM_W'(1);
	assign row_inc  = DIM_W'(row_q) + DIM_W'(1);
	assign last_col = col_inc >= w_eff;
	assign last_row = row_inc >= h_eff;
	assign in_frame = (DIM_W'(col_q) < w_eff) && (DIM_W'(row_q) < h_eff);

	assign xs = DIFF_W'(col_q);
	assign ys = DIFF_W'(row_q);
	assign ws = DIFF_W'(w_eff);
	assign hs = DIFF_W'(h_eff);

	always_comb begin
		for (int i = 0; i < NCORNER; i++) begin
			rs[i] = DIFF_W'(cfg.corner[i].radius);
			if (i == C_TR || i == C_BR) begin
				hit_x[i] = (xs + rs[i]) >= ws;
				dx[i]    = xs + rs[i] - ws;
			end else begin
				hit_x[i] = xs < rs[i];
				dx[i]    = xs - rs[i];
			end
			if (i == C_BL || i == C_BR) begin
				hit_y[i] = (ys + rs[i]) >= hs;
				dy[i]    = ys + rs[i] - hs;
			end else begin
				hit_y[i] = ys < rs[i];
				dy[i]    = ys - rs[i];
			end
		end
	end

	always_comb begin
		push_data.pix.red   = pix_in.in_red;
		push_data.pix.green = pix_in.in_green;
		push_data.pix.blue  = pix_in.in_blue;
		push_data.pix.alpha = pix_in.in_alpha;
		push_data.frame_end = last_col && last_row;
		for (int i = 0; i < NCORNER; i++) begin
			push_data.in_sq[i] = in_frame && hit_x[i] && hit_y[i];
			push_data.mag_x[i] = mag_of(dx[i]);
			push_data.mag_y[i] = mag_of(dy[i]);
		end
	end

	assign pix_in.ready = !q_full;
	assign wr.push      = pix_in.valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (wr.push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_q <= col_inc[CNT_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/rcm_queue.sv */
`default_nettype none

module rcm_queue import rcm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  q_wr_t     wr,
	input  work_t     push_data,
	output logic      full,
	input  wire logic pop,
	output logic      empty,
	output work_t     pop_data
);

	work_t             mem_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = count_q == QCNT_W'(QDEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({wr.push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/rcm_back.sv */
`default_nettype none

module rcm_back import rcm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  work_t     pop_data,
	input  wire logic q_empty,
	output logic      pop,
	rcm_out_if.source pix_out
);

	logic                   v_s1;
	pixel_t                 pix_s1;
	logic                   fe_s1;
	logic [NCORNER-1:0]     inside_s1;
	logic [SQ_W-1:0]        sqx_s1 [NCORNER];
	logic [SQ_W-1:0]        sqy_s1 [NCORNER];
	logic [RSQ_W-1:0]       rsq_s1 [NCORNER];

	logic                   v_s2;
	pixel_t                 pix_s2;
	logic                   filled_s2;
	logic                   fe_s2;

	logic                   s1_ready;
	logic                   s2_ready;
	logic [NCORNER-1:0]     hit;
	logic                   filled;
	logic [COLOR_W-1:0]     color;
	pixel_t                 pix_next;

	assign s2_ready = !v_s2 || pix_out.ready;
	assign s1_ready = !v_s1 || s2_ready;
	assign pop      = !q_empty && s1_ready;

	always_ff @(posedge clk) begin
		if (s1_ready) begin
			pix_s1    <= pop_data.pix;
			fe_s1     <= pop_data.frame_end;
			inside_s1 <= pop_data.in_sq;
			for (int i = 0; i < NCORNER; i++) begin
				sqx_s1[i] <= SQ_W'(pop_data.mag_x[i]) * SQ_W'(pop_data.mag_x[i]);
				sqy_s1[i] <= SQ_W'(pop_data.mag_y[i]) * SQ_W'(pop_data.mag_y[i]);
				rsq_s1[i] <= RSQ_W'(cfg.corner[i].radius) * RSQ_W'(cfg.corner[i].radius);
			end
		end
	end

	always_comb begin
		filled = 1'b0;
		color  = '0;
		for (int i = 0; i < NCORNER; i++) begin
			hit[i] = inside_s1[i] &&
				((SUM_W'(sqx_s1[i]) + SUM_W'(sqy_s1[i])) > SUM_W'(rsq_s1[i]));
			if (hit[i]) begin
				filled = 1'b1;
				color  = cfg.corner[i].color;
			end
		end
		if (filled) begin
			pix_next.red   = color[23:16];
			pix_next.green = color[15:8];
			pix_next.blue  = color[7:0];
			pix_next.alpha = cfg.rgba ? color[31:24] : pix_s1.alpha;
		end else begin
			pix_next = pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			pix_s2    <= pix_next;
			filled_s2 <= filled;
			fe_s2     <= fe_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_ready)
				v_s1 <= !q_empty;
			if (s2_ready)
				v_s2 <= v_s1;
		end
	end

	assign pix_out.valid      = v_s2;
	assign pix_out.out_red    = pix_s2.red;
	assign pix_out.out_green  = pix_s2.green;
	assign pix_out.out_blue   = pix_s2.blue;
	assign pix_out.out_alpha  = pix_s2.alpha;
	assign pix_out.was_filled = filled_s2;
	assign pix_out.frame_end  = fe_s2;

endmodule

`default_nettype wire

/* rtl/rounded_corner_mask.sv */
// Channel    Dir  Handshake     Payload
// pix_in     in   valid/ready   in_red, in_green, in_blue, in_alpha
// pix_out    out  valid/ready   out_red, out_green, out_blue, out_alpha, was_filled, frame_end
// cfg        in   cfg_we only   cfg_index (3b), cfg_wdata (45b)
//
// One pixel per clock sustained while pix_out is ready; a pixel passes the queue, s1, then s2.
// The front classifies against the counters, the back squares in one stage, compares in the next.
// A two-entry queue sits between front and back; pix_in stalls only when it is full.
// Reset clears the counters, the queue and the pipeline, and loads default configuration.
`default_nettype none

module rounded_corner_mask import rcm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	rcm_in_if.sink                    pix_in,
	rcm_out_if.source                 pix_out,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	cfg_t  cfg_q;
	q_wr_t wr;
	work_t push_data;
	work_t pop_data;
	logic  q_full;
	logic  q_empty;
	logic  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= MAX_DIM_V;
			cfg_q.height <= MAX_DIM_V;
			cfg_q.rgba   <= 1'b1;
			cfg_q.corner <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_IMAGE_WIDTH:  cfg_q.width        <= cfg_wdata[DIM_W-1:0];
				CFG_IMAGE_HEIGHT: cfg_q.height       <= cfg_wdata[DIM_W-1:0];
				CFG_PIXEL_FORMAT: cfg_q.rgba         <= cfg_wdata[0];
				CFG_CORNER_TL:    cfg_q.corner[C_TL] <= cfg_wdata;
				CFG_CORNER_TR:    cfg_q.corner[C_TR] <= cfg_wdata;
				CFG_CORNER_BL:    cfg_q.corner[C_BL] <= cfg_wdata;
				CFG_CORNER_BR:    cfg_q.corner[C_BR] <= cfg_wdata;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	rcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.cfg       (cfg_q),
		.wr        (wr),
		.q_full    (q_full),
		.push_data (push_data)
	);

	rcm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_data  (pop_data)
	);

	rcm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_data (pop_data),
		.q_empty  (q_empty),
		.pop      (pop),
		.pix_out  (pix_out)
	);

endmodule

`default_nettype wire

/* rtl/rcm_checker.sv */
`default_nettype none

module rcm_checker import rcm_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_red,
	input wire logic [7:0] out_green,
	input wire logic [7:0] out_blue,
	input wire logic [7:0] out_alpha,
	input wire logic       was_filled,
	input wire logic       frame_end
);

	logic [INFL_W-1:0] inflight_q;
	logic              in_acc;
	logic              out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + INFL_W'(in_acc) - INFL_W'(out_acc);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({out_red, out_green, out_blue, out_alpha,
			was_filled, frame_end}))
		else $error("output payload changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("output transaction without a pending input");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= INFL_W'(MAX_INFLIGHT))
		else $error("more transactions in flight than storage");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> inflight_q >= INFL_W'(QDEPTH))
		else $error("input stalled while queue not full");

endmodule

bind rounded_corner_mask rcm_checker u_rcm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pix_in.valid),
	.in_ready   (pix_in.ready),
	.out_valid  (pix_out.valid),
	.out_ready  (pix_out.ready),
	.out_red    (pix_out.out_red),
	.out_green  (pix_out.out_green),
	.out_blue   (pix_out.out_blue),
	.out_alpha  (pix_out.out_alpha),
	.was_filled (pix_out.was_filled),
	.frame_end  (pix_out.frame_end)
);

`default_nettype wire

/* bench/rounded_corner_mask_tb.sv */
`timescale 1ns / 100ps

module rounded_corner_mask_tb;
	import rcm_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_PIXELS = 600;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct packed {
		pixel_t pix;
		logic   filled;
		logic   fend;
	} masked_t;

	typedef struct {
		bit                   is_write;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		pixel_t               pix;
		bit                   given;
		masked_t              res;
	} step_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	rcm_in_if  px_in ();
	rcm_out_if px_out ();

	rounded_corner_mask u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (px_in),
		.pix_out   (px_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	logic [DIM_W-1:0]   dim_w;
	logic [DIM_W-1:0]   dim_h;
	logic               rgba_on;
	logic [RAD_W-1:0]   arc_rad [NCORNER];
	logic [COLOR_W-1:0] arc_fill [NCORNER];
	int                 col_pos;
	int                 row_pos;

	masked_t pending_pixels [$];
	bit      given_flag [$];
	masked_t given_val [$];

	bit quiet;
	int stall_left;
	int errors;
	int cycles;
	int sent_total;
	int phases;
	int filled_cnt;
	int fend_cnt;

	step_t steps [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp_dim(logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	function automatic longint lmin(longint a, longint b);
		return a < b ? a : b;
	endfunction

	function automatic masked_t mask_pixel(pixel_t p);
		longint w, h, x, y, r, cx, cy;
		bit in_sq;
		bit hit;
		logic [COLOR_W-1:0] fill;
		masked_t res;
		w = clamp_dim(dim_w);
		h = clamp_dim(dim_h);
		x = col_pos;
		y = row_pos;
		hit = 1'b0;
		fill = '0;
		for (int k = 0; k < NCORNER; k++) begin
			r = arc_rad[k];
			case (k)
				C_TL: begin
					in_sq = x < lmin(w, r) && y < lmin(h, r);
					cx = r;
					cy = r;
				end
				C_TR: begin
					in_sq = x >= w - lmin(w, r) && y < lmin(h, r);
					cx = w - r;
					cy = r;
				end
				C_BL: begin
					in_sq = x < lmin(w, r) && y >= h - lmin(h, r);
					cx = r;
					cy = h - r;
				end
				default: begin
					in_sq = x >= w - lmin(w, r) && y >= h - lmin(h, r);
					cx = w - r;
					cy = h - r;
				end
			endcase
			if (x < w && y < h && in_sq && (x - cx) * (x - cx) + (y - cy) * (y - cy) > r * r) begin
				hit = 1'b1;
				fill = arc_fill[k];
			end
		end
		res.pix = p;
		if (hit) begin
			res.pix.red = fill[23:16];
			res.pix.green = fill[15:8];
			res.pix.blue = fill[7:0];
			if (rgba_on)
				res.pix.alpha = fill[31:24];
		end
		res.filled = hit;
		res.fend = 1'b0;
		if (x >= w - 1) begin
			col_pos = 0;
			if (y >= h - 1) begin
				row_pos = 0;
				res.fend = 1'b1;
			end else begin
				row_pos = row_pos + 1;
			end
		end else begin
			col_pos = col_pos + 1;
		end
		return res;
	endfunction

	function automatic int idle_len();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 94)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic logic [CFG_W-1:0] corner_word(int r, logic [COLOR_W-1:0] c);
		return {RAD_W'(r), c};
	endfunction

	function automatic step_t reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		step_t s;
		s = '{default: '0};
		s.is_write = 1'b1;
		s.idx = idx;
		s.data = data;
		return s;
	endfunction

	function automatic step_t pix_any(logic [31:0] p);
		step_t s;
		s = '{default: '0};
		s.pix = p;
		return s;
	endfunction

	function automatic step_t pix_known(logic [31:0] p, logic [31:0] o, logic f, logic e);
		step_t s;
		s = pix_any(p);
		s.given = 1'b1;
		s.res.pix = o;
		s.res.filled = f;
		s.res.fend = e;
		return s;
	endfunction

	function automatic int pick_radius(int span);
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 0;
		if (roll == 1)
			return $urandom_range(0, 8191);
		if (roll == 2)
			return 8191;
		return $urandom_range(1, span + 1);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		while (pending_pixels.size() != 0)
			@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_pixel(pixel_t p, bit given, masked_t res);
		int gap;
		gap = idle_len();
		if (gap > 0)
			repeat (gap) @(negedge clk);
		given_flag.push_back(given);
		given_val.push_back(res);
		px_in.valid = 1'b1;
		px_in.in_red = p.red;
		px_in.in_green = p.green;
		px_in.in_blue = p.blue;
		px_in.in_alpha = p.alpha;
		do
			@(posedge clk);
		while (!px_in.ready);
		@(negedge clk);
		px_in.valid = 1'b0;
		sent_total++;
	endtask

	task automatic random_phase();
		int w, h, span, n;
		longint area;
		cfg_idx_t order [$];
		logic [CFG_W-1:0] word;
		quiet = ($urandom_range(0, 4) == 0);
		case ($urandom_range(0, 15))
			0: begin
				w = $urandom_range(4097, 8191);
				h = $urandom_range(1, 8);
			end
			1: begin
				w = 0;
				h = $urandom_range(0, 12);
			end
			2: begin
				w = $urandom_range(1, 12);
				h = $urandom_range(4096, 8191);
			end
			default: begin
				w = $urandom_range(1, 16);
				h = $urandom_range(1, 16);
			end
		endcase
		span = int'(lmin(40, clamp_dim(DIM_W'(w)) > clamp_dim(DIM_W'(h)) ?
			clamp_dim(DIM_W'(w)) : clamp_dim(DIM_W'(h))));
		order = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_PIXEL_FORMAT, CFG_CORNER_TL,
			CFG_CORNER_TR, CFG_CORNER_BL, CFG_CORNER_BR};
		order.shuffle();
		foreach (order[i]) begin
			case (order[i])
				CFG_IMAGE_WIDTH:  word = {32'($urandom), DIM_W'(w)};
				CFG_IMAGE_HEIGHT: word = {32'($urandom), DIM_W'(h)};
				CFG_PIXEL_FORMAT: word = {13'($urandom), 32'($urandom)};
				default:          word = corner_word(pick_radius(span), $urandom);
			endcase
			write_reg(order[i], word);
		end
		area = clamp_dim(DIM_W'(w)) * clamp_dim(DIM_W'(h));
		n = int'(lmin(area + $urandom_range(0, 16), 1000)) + int'($urandom_range(0, 1)) * int'(lmin(area, 150));
		if (n > 150)
			n = $urandom_range(20, 60);
		if (n < 6)
			n = 6;
		repeat (n)
			send_pixel(pixel_t'($urandom), 1'b0, '0);
		phases++;
	endtask

	always @(posedge clk) begin : track
		masked_t want;
		masked_t got;
		bit g;
		masked_t gv;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  dim_w = cfg_wdata[DIM_W-1:0];
					CFG_IMAGE_HEIGHT: dim_h = cfg_wdata[DIM_W-1:0];
					CFG_PIXEL_FORMAT: rgba_on = cfg_wdata[0];
					CFG_CORNER_TL:    {arc_rad[C_TL], arc_fill[C_TL]} = cfg_wdata;
					CFG_CORNER_TR:    {arc_rad[C_TR], arc_fill[C_TR]} = cfg_wdata;
					CFG_CORNER_BL:    {arc_rad[C_BL], arc_fill[C_BL]} = cfg_wdata;
					CFG_CORNER_BR:    {arc_rad[C_BR], arc_fill[C_BR]} = cfg_wdata;
					default: ;
				endcase
			end
			if (px_in.valid && px_in.ready) begin
				want = mask_pixel({px_in.in_red, px_in.in_green, px_in.in_blue, px_in.in_alpha});
				g = given_flag.pop_front();
				gv = given_val.pop_front();
				if (g)
					want = gv;
				pending_pixels.push_back(want);
			end
			if (px_out.valid && px_out.ready) begin
				got.pix = {px_out.out_red, px_out.out_green, px_out.out_blue, px_out.out_alpha};
				got.filled = px_out.was_filled;
				got.fend = px_out.frame_end;
				filled_cnt += got.filled;
				fend_cnt += got.fend;
				if (pending_pixels.size() == 0) begin
					$error("result with no pixel outstanding: %h", got);
					errors++;
				end else begin
					want = pending_pixels.pop_front();
					if (got.pix.red !== want.pix.red) begin
						$error("out_red: expected %h, got %h", want.pix.red, got.pix.red);
						errors++;
					end
					if (got.pix.green !== want.pix.green) begin
						$error("out_green: expected %h, got %h", want.pix.green, got.pix.green);
						errors++;
					end
					if (got.pix.blue !== want.pix.blue) begin
						$error("out_blue: expected %h, got %h", want.pix.blue, got.pix.blue);
						errors++;
					end
					if (got.pix.alpha !== want.pix.alpha) begin
						$error("out_alpha: expected %h, got %h", want.pix.alpha, got.pix.alpha);
						errors++;
					end
					if (got.filled !== want.filled) begin
						$error("was_filled: expected %b, got %b", want.filled, got.filled);
						errors++;
					end
					if (got.fend !== want.fend) begin
						$error("frame_end: expected %b, got %b", want.fend, got.fend);
						errors++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			px_out.ready = 1'b0;
			stall_left--;
		end else begin
			px_out.ready = 1'b1;
			stall_left = idle_len();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding", cycles,
				pending_pixels.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		px_in.valid = 1'b0;
		px_in.in_red = '0;
		px_in.in_green = '0;
		px_in.in_blue = '0;
		px_in.in_alpha = '0;
		px_out.ready = 1'b0;
		dim_w = DIM_W'(MAX_DIM);
		dim_h = DIM_W'(MAX_DIM);
		rgba_on = 1'b1;
		for (int k = 0; k < NCORNER; k++) begin
			arc_rad[k] = '0;
			arc_fill[k] = '0;
		end
		col_pos = 0;
		row_pos = 0;
		quiet = 1'b0;
		stall_left = 0;
		errors = 0;
		cycles = 0;
		sent_total = 0;
		phases = 0;
		filled_cnt = 0;
		fend_cnt = 0;

		steps = '{
			pix_known(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0),
			pix_known(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0),
			reg_write(CFG_IMAGE_WIDTH, 45'h0),
			reg_write(CFG_IMAGE_HEIGHT, 45'h1FFF_FFFF_E000),
			pix_known(32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1),
			pix_known(32'h9ABC_DEF0, 32'h9ABC_DEF0, 1'b0, 1'b1),
			reg_write(CFG_PIXEL_FORMAT, 45'h0),
			reg_write(CFG_CORNER_TL, corner_word(8191, 32'h1122_3344)),
			pix_known(32'hA5A5_A5A5, 32'h2233_44A5, 1'b1, 1'b1),
			reg_write(CFG_PIXEL_FORMAT, 45'h1FFF_FFFF_FFFF),
			pix_known(32'h5A5A_5A5A, 32'h2233_4411, 1'b1, 1'b1),
			reg_write(CFG_CORNER_BR, corner_word(8191, 32'hAABB_CCDD)),
			pix_known(32'h0000_0000, 32'hBBCC_DDAA, 1'b1, 1'b1),
			reg_write(CFG_UNUSED, 45'h1FFF_FFFF_FFFF),
			pix_known(32'hFFFF_FFFF, 32'hBBCC_DDAA, 1'b1, 1'b1),
			reg_write(CFG_IMAGE_WIDTH, 45'd8191),
			reg_write(CFG_IMAGE_HEIGHT, 45'd4097),
			pix_any(32'h0F0F_0F0F),
			pix_any(32'hF0F0_F0F0),
			reg_write(CFG_IMAGE_WIDTH, 45'd4),
			reg_write(CFG_IMAGE_HEIGHT, 45'd4),
			reg_write(CFG_CORNER_TL, corner_word(2, 32'h80FF_0000)),
			reg_write(CFG_CORNER_TR, corner_word(2, 32'h8000_FF00)),
			reg_write(CFG_CORNER_BL, corner_word(3, 32'h8000_00FF)),
			reg_write(CFG_CORNER_BR, corner_word(4, 32'hFF80_8080)),
			pix_any(32'h0102_0304), pix_any(32'h1112_1314),
			pix_any(32'h2122_2324), pix_any(32'h3132_3334),
			pix_any(32'h4142_4344), pix_any(32'h5152_5354),
			pix_any(32'h6162_6364), pix_any(32'h7172_7374),
			pix_any(32'h8182_8384), pix_any(32'h9192_9394),
			pix_any(32'hA1A2_A3A4), pix_any(32'hB1B2_B3B4),
			pix_any(32'hC1C2_C3C4), pix_any(32'hD1D2_D3D4),
			pix_any(32'hE1E2_E3E4), pix_any(32'hF1F2_F3F4)
		};

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (steps[i]) begin
			if (steps[i].is_write)
				write_reg(steps[i].idx, steps[i].data);
			else
				send_pixel(steps[i].pix, steps[i].given, steps[i].res);
		end

		while (sent_total < RANDOM_PIXELS + steps.size())
			random_phase();

		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("%0d pixels over %0d random configurations plus the directed table", sent_total,
			phases);
		$display("%0d pixels filled by a corner, %0d frame ends seen, %0d mismatches", filled_cnt,
			fend_cnt, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
rtl/rcm_pkg.sv
rtl/rcm_ifs.sv
rtl/rcm_front.sv
rtl/rcm_queue.sv
rtl/rcm_back.sv
rtl/rounded_corner_mask.sv
rtl/rcm_checker.sv
bench/rounded_corner_mask_tb.sv
